/* design/ttq_pkg.sv */
// Package for the touch threshold qualifier: field widths, register indexes,
// reset values and shared types.
// Used by ttq_avg and touch_threshold_qualifier_top.
package ttq_pkg;

   localparam int NOW_W             = 32;
   localparam int SAMPLE_W          = 10;
   localparam int LEVEL_W           = 10;
   localparam int COUNT_W           = 8;
   localparam int LOCKOUT_W         = 16;
   localparam int REPEAT_W          = 6;
   localparam int NUM_SAMPLE_FIELDS = 5;
   localparam int SAMPLE_COUNT_DEFAULT = 5;

   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef logic [SAMPLE_W-1:0]                         sample_type;
   typedef sample_type [NUM_SAMPLE_FIELDS-1:0]          sample_arr_type;
   typedef logic [LEVEL_W-1:0]                          level_type;
   typedef logic [COUNT_W-1:0]                          count_type;
   typedef logic [NOW_W-1:0]                            now_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKOUT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOUCH_THR  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_THR   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT     = 2'd3;

   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET   = 16'd500;
   localparam level_type            TOUCH_THR_RESET = 10'd900;
   localparam level_type            NEAR_THR_RESET  = 10'd1000;
   localparam logic [REPEAT_W-1:0]  REPEAT_RESET    = 6'd3;
   localparam level_type            HELD_LEVEL_RESET = 10'd900;

endpackage

/* design/ttq_avg.sv */
// Burst averager: sums SAMPLE_COUNT samples and divides by the count with a
// reciprocal multiply. Depends on ttq_pkg.
module ttq_avg #(
   parameter int SAMPLE_COUNT = ttq_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  ttq_pkg::sample_arr_type samples,
   output ttq_pkg::level_type      level
);
   import ttq_pkg::*;

   localparam int SUM_W     = $clog2(((1 << SAMPLE_W) - 1) * SAMPLE_COUNT + 1);
   localparam int DIV_SHIFT = SUM_W + 4;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << DIV_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;

   always_comb begin
      sum = '0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         sum = sum + SUM_W'(samples[i % NUM_SAMPLE_FIELDS]);
      end
   end

   assign prod  = PROD_W'(sum) * PROD_W'(RECIP);
   assign level = prod[DIV_SHIFT +: LEVEL_W];

endmodule

/* design/touch_threshold_qualifier_top.sv */
// Top level of the touch threshold qualifier: stream ports, input and result
// registers, configuration registers and the touch decision state.
// Depends on ttq_pkg and ttq_avg.
//
//   Channel  Direction  Payload (lowest bit first)
//   req      in         now_ms[31:0], sample_a..sample_e (10 bits each), pad
//   rsp      out        touched, sampled, level[9:0], pad
//   csr      in         write enable, register index, 16-bit write data
//
// A transfer on req is registered in the input register, evaluated there and
// written to the result register once that register is free, and one item is
// taken every cycle while rsp is not stalled. The result register can hold
// one item while the next one waits in the input register. Reset is
// synchronous and restores the register defaults and the decision state.
module touch_threshold_qualifier_top #(
   parameter int SAMPLE_COUNT = ttq_pkg::SAMPLE_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // now_ms, sample_a, sample_b, sample_c, sample_d, sample_e
   input  logic [ttq_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // touched, sampled, level
   output logic [ttq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [ttq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ttq_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ttq_pkg::*;

   logic                  in_vld_ff;
   now_type               in_now_ff;
   sample_arr_type        in_samples_ff;

   logic                  rsp_vld_ff;
   logic                  rsp_touched_ff;
   logic                  rsp_sampled_ff;
   level_type             rsp_level_ff;

   now_type               last_touch_ff, last_touch_in;
   count_type             near_cnt_ff, near_cnt_in;
   count_type             far_cnt_ff, far_cnt_in;
   level_type             held_level_ff, held_level_in;

   logic [LOCKOUT_W-1:0]  lockout_ff;
   level_type             touch_thr_ff;
   level_type             near_thr_ff;
   logic [REPEAT_W-1:0]   repeat_ff;

   logic                  rsp_free;
   logic                  advance;
   logic                  take;
   level_type             avg;
   now_type               last_eff;
   now_type               elapsed;
   logic                  go;
   logic                  touch;
   count_type             near_bump;
   count_type             far_bump;
   count_type             repeat3;

   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && rsp_free;
   assign req_tready = !in_vld_ff || rsp_free;
   assign take       = req_tvalid && req_tready;

   ttq_avg #(
      .SAMPLE_COUNT(SAMPLE_COUNT)
   ) u_avg (
      .samples(in_samples_ff),
      .level  (avg)
   );

   always_comb begin
      last_eff  = (last_touch_ff > in_now_ff) ? '0 : last_touch_ff;
      elapsed   = in_now_ff - last_eff;
      go        = elapsed >= NOW_W'(lockout_ff);
      near_bump = (near_cnt_ff == '1) ? near_cnt_ff : near_cnt_ff + 1'b1;
      far_bump  = (far_cnt_ff == '1) ? far_cnt_ff : far_cnt_ff + 1'b1;
      repeat3   = (COUNT_W'(repeat_ff) << 1) + COUNT_W'(repeat_ff);

      touch         = 1'b0;
      last_touch_in = last_eff;
      near_cnt_in   = near_cnt_ff;
      far_cnt_in    = far_cnt_ff;
      held_level_in = held_level_ff;

      if (go) begin
         held_level_in = avg;
         touch         = avg < touch_thr_ff;
         if (avg < near_thr_ff) begin
            near_cnt_in = near_bump;
            if (near_bump > COUNT_W'(repeat_ff)) begin
               touch = 1'b1;
            end
         end else begin
            far_cnt_in = far_bump;
            if (far_bump > repeat3) begin
               near_cnt_in = '0;
               far_cnt_in  = '0;
            end
         end
         if (touch) begin
            last_touch_in = in_now_ff;
            near_cnt_in   = '0;
            far_cnt_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_now_ff <= req_tdata[NOW_W-1:0];
         for (int i = 0; i < NUM_SAMPLE_FIELDS; i++) begin
            in_samples_ff[i] <= req_tdata[NOW_W + i*SAMPLE_W +: SAMPLE_W];
         end
      end
      if (advance) begin
         rsp_touched_ff <= touch;
         rsp_sampled_ff <= go;
         rsp_level_ff   <= held_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         last_touch_ff <= '0;
         near_cnt_ff   <= '0;
         far_cnt_ff    <= '0;
         held_level_ff <= HELD_LEVEL_RESET;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (rsp_free) begin
            rsp_vld_ff <= in_vld_ff;
         end
         if (advance) begin
            last_touch_ff <= last_touch_in;
            near_cnt_ff   <= near_cnt_in;
            far_cnt_ff    <= far_cnt_in;
            held_level_ff <= held_level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff   <= LOCKOUT_RESET;
         touch_thr_ff <= TOUCH_THR_RESET;
         near_thr_ff  <= NEAR_THR_RESET;
         repeat_ff    <= REPEAT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCKOUT:   lockout_ff   <= csr_wdata[LOCKOUT_W-1:0];
            CSR_TOUCH_THR: touch_thr_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_NEAR_THR:  near_thr_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_REPEAT:    repeat_ff    <= csr_wdata[REPEAT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - LEVEL_W - 2){1'b0}},
                        rsp_level_ff, rsp_sampled_ff, rsp_touched_ff};

endmodule
